>>> rtl/core/cerq_pkg.sv
// Shared constants, types and ring helpers for the coalescing event ring queue.
`timescale 1ns / 1ps
`default_nettype none
package cerq_pkg;

   // Ring geometry
   localparam int QUEUE_SLOTS = 32;
   localparam int PTR_W       = $clog2(QUEUE_SLOTS);

   // Field widths
   localparam int TYPE_W = 4;
   localparam int ARG_W  = 32;

   // Opcodes
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   // Reset value of the pointer-movement type code
   localparam logic [TYPE_W-1:0] MOUSE_CODE_RESET = TYPE_W'(1);

   typedef logic [PTR_W-1:0] ptr_type;

   // Controller to datapath commands
   typedef struct packed {
      logic latch;   // capture the accepted transfer
      logic rd_en;   // read the addressed ring entry
      logic exec;    // update ring, pointers and result register
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic rsp_busy;  // result register full and not being taken
   } status_type;

   function automatic ptr_type ring_next(input ptr_type i);
      ptr_type r;
      if (i == PTR_W'(QUEUE_SLOTS - 1)) r = '0;
      else                              r = i + PTR_W'(1);
      return r;
   endfunction

   function automatic ptr_type ring_prev(input ptr_type i);
      ptr_type r;
      if (i == '0) r = PTR_W'(QUEUE_SLOTS - 1);
      else         r = i - PTR_W'(1);
      return r;
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/coalescing_event_ring_queue.sv
// Top level of the coalescing event ring queue: controller plus datapath.
//
//   channel   direction  handshake               payload
//   req_      in         req_valid / req_stall   opcode, event_type, arg_a..arg_c
//   rsp_      out        rsp_valid / rsp_stall   pop_valid, out_type, out_a..out_c,
//                                                merged, dropped_oldest
//   csr_      in         csr_wr_en               csr_wr_data (pointer-movement code)
//
// Each item passes through three steps: the transfer, a registered read of the
// ring memories, then the update of ring, pointers and result register.
// req_stall stays high from the transfer until the update is done.
// The update waits while the previous result is still held by rsp_stall.
// Reset zeroes both pointers and sets the code to 1; the ring memories are
// not cleared, so no clearing pass follows reset.
`timescale 1ns / 1ps
`default_nettype none
module coalescing_event_ring_queue
   import cerq_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_wr_en,
   input  wire logic [TYPE_W-1:0]        csr_wr_data,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic                     req_opcode,
   input  wire logic [TYPE_W-1:0]        req_event_type,
   input  wire logic signed [ARG_W-1:0]  req_arg_a,
   input  wire logic signed [ARG_W-1:0]  req_arg_b,
   input  wire logic signed [ARG_W-1:0]  req_arg_c,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic                          rsp_pop_valid,
   output logic [TYPE_W-1:0]             rsp_out_type,
   output logic signed [ARG_W-1:0]       rsp_out_a,
   output logic signed [ARG_W-1:0]       rsp_out_b,
   output logic signed [ARG_W-1:0]       rsp_out_c,
   output logic                          rsp_merged,
   output logic                          rsp_dropped_oldest
);

   cmd_type    cmd;
   status_type status;

   cerq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   cerq_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_opcode         (req_opcode),
      .req_event_type     (req_event_type),
      .req_arg_a          (req_arg_a),
      .req_arg_b          (req_arg_b),
      .req_arg_c          (req_arg_c),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pop_valid      (rsp_pop_valid),
      .rsp_out_type       (rsp_out_type),
      .rsp_out_a          (rsp_out_a),
      .rsp_out_b          (rsp_out_b),
      .rsp_out_c          (rsp_out_c),
      .rsp_merged         (rsp_merged),
      .rsp_dropped_oldest (rsp_dropped_oldest)
   );

   // A transfer closes the input until its update is done
   a_accept_closes: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input open right after a transfer");

   // The update never overwrites a result still held
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |-> !(rsp_valid && rsp_stall))
      else $error("result overwritten while stalled");

   // Every update presents a result
   a_exec_presents: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> rsp_valid)
      else $error("update without result");

   // A pop result carries no push flags
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_pop_valid && (rsp_merged || rsp_dropped_oldest)))
      else $error("pop and push flags together");

endmodule
`default_nettype wire

>>> rtl/core/cerq_ctrl.sv
// Sequencing state machine: accept, ring read, update.
`timescale 1ns / 1ps
`default_nettype none
module cerq_ctrl
   import cerq_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  status_type      status,
   output cmd_type         cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      stall_ff, stall_in;
   logic      accept;

   assign accept    = req_valid && !stall_ff;
   assign req_stall = stall_ff;

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      stall_in  = stall_ff;
      cmd.latch = 1'b0;
      cmd.rd_en = 1'b0;
      cmd.exec  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.latch = 1'b1;
               stall_in  = 1'b1;
               state_in  = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_EXEC;
         end
         ST_EXEC: begin
            // wait here while the previous result is still held
            if (!status.rsp_busy) begin
               cmd.exec = 1'b1;
               stall_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            stall_in = 1'b0;
         end
      endcase
   end

   // State and registered stall
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         stall_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         stall_ff <= stall_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/core/cerq_datapath.sv
// Ring memories, pointers, coalescing compare and result register.
`timescale 1ns / 1ps
`default_nettype none
module cerq_datapath
   import cerq_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  cmd_type                       cmd,
   output status_type                    status,
   input  wire logic                     csr_wr_en,
   input  wire logic [TYPE_W-1:0]        csr_wr_data,
   input  wire logic                     req_opcode,
   input  wire logic [TYPE_W-1:0]        req_event_type,
   input  wire logic signed [ARG_W-1:0]  req_arg_a,
   input  wire logic signed [ARG_W-1:0]  req_arg_b,
   input  wire logic signed [ARG_W-1:0]  req_arg_c,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic                          rsp_pop_valid,
   output logic [TYPE_W-1:0]             rsp_out_type,
   output logic signed [ARG_W-1:0]       rsp_out_a,
   output logic signed [ARG_W-1:0]       rsp_out_b,
   output logic signed [ARG_W-1:0]       rsp_out_c,
   output logic                          rsp_merged,
   output logic                          rsp_dropped_oldest
);

   // Ring storage
   logic [TYPE_W-1:0] type_mem   [QUEUE_SLOTS];
   logic [ARG_W-1:0]  first_mem  [QUEUE_SLOTS];
   logic [ARG_W-1:0]  second_mem [QUEUE_SLOTS];
   logic [ARG_W-1:0]  third_mem  [QUEUE_SLOTS];

   logic [TYPE_W-1:0] mouse_code_ff;
   ptr_type           head_ff, head_in;
   ptr_type           tail_ff, tail_in;

   // Captured transfer
   logic              op_ff;
   logic [TYPE_W-1:0] ty_ff;
   logic [ARG_W-1:0]  a_ff, b_ff, c_ff;

   // Registered read data
   logic [TYPE_W-1:0] rd_type_ff;
   logic [ARG_W-1:0]  rd_a_ff, rd_b_ff, rd_c_ff;
   ptr_type           rd_addr;

   // Result register
   logic              rsp_valid_ff;
   logic              pop_valid_ff, merged_ff, dropped_ff;
   logic [TYPE_W-1:0] out_type_ff;
   logic [ARG_W-1:0]  out_a_ff, out_b_ff, out_c_ff;

   // Update decisions
   logic              not_empty, do_merge, do_append, do_pop, full;
   logic              wr_args, wr_all;
   ptr_type           wr_addr;

   assign status.rsp_busy = rsp_valid_ff && rsp_stall;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset)          mouse_code_ff <= MOUSE_CODE_RESET;
      else if (csr_wr_en) mouse_code_ff <= csr_wr_data;
   end

   // Capture the accepted transfer
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff <= req_opcode;
         ty_ff <= req_event_type;
         a_ff  <= req_arg_a;
         b_ff  <= req_arg_b;
         c_ff  <= req_arg_c;
      end
   end

   // Pop reads the oldest entry, push inspects the newest
   assign rd_addr = (op_ff == OP_POP) ? head_ff : ring_prev(tail_ff);

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_type_ff <= type_mem[rd_addr];
         rd_a_ff    <= first_mem[rd_addr];
         rd_b_ff    <= second_mem[rd_addr];
         rd_c_ff    <= third_mem[rd_addr];
      end
   end

   // Merge, append or pop
   always_comb begin
      not_empty = (head_ff != tail_ff);
      full      = (ring_next(tail_ff) == head_ff);
      do_merge  = (op_ff == OP_PUSH) && (ty_ff == mouse_code_ff) && not_empty &&
                  (rd_type_ff == ty_ff) && (rd_c_ff == c_ff);
      do_append = (op_ff == OP_PUSH) && !do_merge;
      do_pop    = (op_ff == OP_POP) && not_empty;
      wr_args   = cmd.exec && (do_merge || do_append);
      wr_all    = cmd.exec && do_append;
      wr_addr   = do_merge ? ring_prev(tail_ff) : tail_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      if (do_append) begin
         tail_in = ring_next(tail_ff);
         if (full) head_in = ring_next(head_ff);
      end
      if (do_pop) head_in = ring_next(head_ff);
   end

   // Ring writes
   always_ff @(posedge clock) begin
      if (wr_args) begin
         first_mem[wr_addr]  <= a_ff;
         second_mem[wr_addr] <= b_ff;
      end
      if (wr_all) begin
         type_mem[wr_addr]  <= ty_ff;
         third_mem[wr_addr] <= c_ff;
      end
   end

   // Pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
      end else if (cmd.exec) begin
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
   end

   // Result valid
   always_ff @(posedge clock) begin
      if (reset)                rsp_valid_ff <= 1'b0;
      else if (cmd.exec)        rsp_valid_ff <= 1'b1;
      else if (!rsp_stall)      rsp_valid_ff <= 1'b0;
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         pop_valid_ff <= do_pop;
         merged_ff    <= do_merge;
         dropped_ff   <= do_append && full;
         out_type_ff  <= do_pop ? rd_type_ff : '0;
         out_a_ff     <= do_pop ? rd_a_ff : '0;
         out_b_ff     <= do_pop ? rd_b_ff : '0;
         out_c_ff     <= do_pop ? rd_c_ff : '0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pop_valid      = pop_valid_ff;
   assign rsp_out_type       = out_type_ff;
   assign rsp_out_a          = out_a_ff;
   assign rsp_out_b          = out_b_ff;
   assign rsp_out_c          = out_c_ff;
   assign rsp_merged         = merged_ff;
   assign rsp_dropped_oldest = dropped_ff;

endmodule
`default_nettype wire

>>> sim/coalescing_event_ring_queue_monitor.sv
// Reply monitor for the coalescing event ring queue: predicts every reply and compares it.
`timescale 1ns / 1ps
module coalescing_event_ring_queue_monitor
   import cerq_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [TYPE_W-1:0]       csr_wr_data,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  logic                    req_opcode,
   input  logic [TYPE_W-1:0]       req_event_type,
   input  logic [ARG_W-1:0]        req_arg_a,
   input  logic [ARG_W-1:0]        req_arg_b,
   input  logic [ARG_W-1:0]        req_arg_c,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  logic                    rsp_pop_valid,
   input  logic [TYPE_W-1:0]       rsp_out_type,
   input  logic [ARG_W-1:0]        rsp_out_a,
   input  logic [ARG_W-1:0]        rsp_out_b,
   input  logic [ARG_W-1:0]        rsp_out_c,
   input  logic                    rsp_merged,
   input  logic                    rsp_dropped_oldest,
   output int                      failures,
   output int                      outstanding,
   output int                      replies_checked,
   output int                      coalesced_count,
   output int                      dropped_count
);

   typedef struct packed {
      logic [TYPE_W-1:0] kind;
      logic [ARG_W-1:0]  a;
      logic [ARG_W-1:0]  b;
      logic [ARG_W-1:0]  c;
   } ring_entry_type;

   typedef struct packed {
      logic              pop_valid;
      logic [TYPE_W-1:0] out_type;
      logic [ARG_W-1:0]  out_a;
      logic [ARG_W-1:0]  out_b;
      logic [ARG_W-1:0]  out_c;
      logic              merged;
      logic              dropped_oldest;
   } queue_reply_type;

   // Shadow copy of the ring, its pointers and the pointer-movement code
   ring_entry_type    ring [QUEUE_SLOTS];
   ptr_type           head;
   ptr_type           tail;
   logic [TYPE_W-1:0] pointer_code;

   queue_reply_type   awaited_replies [$];
   queue_reply_type   want;
   queue_reply_type   got;

   initial begin
      failures        = 0;
      outstanding     = 0;
      replies_checked = 0;
      coalesced_count = 0;
      dropped_count   = 0;
   end

   function automatic ptr_type next_slot(input ptr_type p);
      return ptr_type'((int'(p) + 1) % QUEUE_SLOTS);
   endfunction

   // Applies one request to the shadow ring and returns the reply it must give
   function automatic queue_reply_type apply_request(input logic op,
                                                     input logic [TYPE_W-1:0] kind,
                                                     input logic [ARG_W-1:0] a,
                                                     input logic [ARG_W-1:0] b,
                                                     input logic [ARG_W-1:0] c);
      queue_reply_type r;
      ring_entry_type  e;
      ptr_type         newest;
      logic            coalesce;
      r        = '0;
      coalesce = 1'b0;
      if (op == OP_PUSH) begin
         // a pointer move folds into the newest entry when the buttons match
         if (kind == pointer_code && head != tail) begin
            newest = ptr_type'((int'(tail) + QUEUE_SLOTS - 1) % QUEUE_SLOTS);
            e = ring[newest];
            if (e.kind == kind && e.c == c) begin
               e.a          = a;
               e.b          = b;
               ring[newest] = e;
               coalesce     = 1'b1;
               r.merged     = 1'b1;
            end
         end
         // append, giving up the oldest entry when the ring is full
         if (!coalesce) begin
            if (next_slot(tail) == head) begin
               head             = next_slot(head);
               r.dropped_oldest = 1'b1;
            end
            e.kind     = kind;
            e.a        = a;
            e.b        = b;
            e.c        = c;
            ring[tail] = e;
            tail       = next_slot(tail);
         end
      end else if (head != tail) begin
         e           = ring[head];
         r.pop_valid = 1'b1;
         r.out_type  = e.kind;
         r.out_a     = e.a;
         r.out_b     = e.b;
         r.out_c     = e.c;
         head        = next_slot(head);
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [ARG_W-1:0] seen,
                                  input logic [ARG_W-1:0] wanted);
      if (failures < 40)
         $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, seen, wanted);
      failures++;
   endtask

   task automatic check_field(input string what, input logic [ARG_W-1:0] seen,
                              input logic [ARG_W-1:0] wanted);
      if (seen !== wanted) report_mismatch(what, seen, wanted);
   endtask

   // Reply side first, then the request taken at the same edge, then the register
   always @(posedge clock) begin
      if (reset) begin
         head         = '0;
         tail         = '0;
         pointer_code = MOUSE_CODE_RESET;
         awaited_replies.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_pop_valid, rsp_out_type, rsp_out_a, rsp_out_b, rsp_out_c,
                   rsp_merged, rsp_dropped_oldest};
            if (awaited_replies.size() == 0) begin
               report_mismatch("reply with nothing pending", got.out_a, '0);
            end else begin
               want = awaited_replies.pop_front();
               check_field("pop_valid", got.pop_valid, want.pop_valid);
               check_field("out_type", got.out_type, want.out_type);
               check_field("out_a", got.out_a, want.out_a);
               check_field("out_b", got.out_b, want.out_b);
               check_field("out_c", got.out_c, want.out_c);
               check_field("merged", got.merged, want.merged);
               check_field("dropped_oldest", got.dropped_oldest, want.dropped_oldest);
               replies_checked <= replies_checked + 1;
               if (want.merged) coalesced_count <= coalesced_count + 1;
               if (want.dropped_oldest) dropped_count <= dropped_count + 1;
            end
         end
         if (req_valid && !req_stall)
            awaited_replies.push_back(apply_request(req_opcode, req_event_type,
                                                    req_arg_a, req_arg_b, req_arg_c));
         if (csr_wr_en) pointer_code = csr_wr_data;
      end
      outstanding <= awaited_replies.size();
   end

endmodule

>>> sim/coalescing_event_ring_queue_test.sv
// Testbench top for the coalescing event ring queue: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module coalescing_event_ring_queue_test;
   import cerq_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int LONG_HOLD    = 300;
   localparam int PHASE_ITEMS  = 175;
   localparam int PHASES       = 8;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      csr_wr_en;
   logic [TYPE_W-1:0]         csr_wr_data;
   logic                      req_valid;
   logic                      req_stall;
   logic                      req_opcode;
   logic [TYPE_W-1:0]         req_event_type;
   logic signed [ARG_W-1:0]   req_arg_a;
   logic signed [ARG_W-1:0]   req_arg_b;
   logic signed [ARG_W-1:0]   req_arg_c;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic                      rsp_pop_valid;
   logic [TYPE_W-1:0]         rsp_out_type;
   logic signed [ARG_W-1:0]   rsp_out_a;
   logic signed [ARG_W-1:0]   rsp_out_b;
   logic signed [ARG_W-1:0]   rsp_out_c;
   logic                      rsp_merged;
   logic                      rsp_dropped_oldest;

   int                        failures;
   int                        outstanding;
   int                        replies_checked;
   int                        coalesced_count;
   int                        dropped_count;

   int                        requests_sent  = 0;
   int unsigned               cycle_count    = 0;
   logic [TYPE_W-1:0]         mouse_code     = MOUSE_CODE_RESET;
   bit                        sender_idles   = 1'b0;
   bit                        receiver_idles = 1'b0;
   bit                        hold_replies   = 1'b0;

   coalescing_event_ring_queue dut (.*);

   coalescing_event_ring_queue_monitor monitor (.*);

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d replies outstanding", cycle_count, outstanding);
         $display("simulation failed");
         $finish;
      end
   end

   // Reply side: random stall bursts, plus one long hold on request
   initial begin : reply_side
      rsp_stall <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_replies) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            hold_replies = 1'b0;
         end else if (receiver_idles && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   // Offers one request, waits for its transfer, then maybe leaves a gap
   task automatic offer(input logic op, input logic [TYPE_W-1:0] kind,
                        input logic [ARG_W-1:0] a, input logic [ARG_W-1:0] b,
                        input logic [ARG_W-1:0] c);
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_event_type <= kind;
      req_arg_a      <= a;
      req_arg_b      <= b;
      req_arg_c      <= c;
      do @(posedge clock); while (req_stall);
      requests_sent++;
      if (sender_idles && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   task automatic pop_event();
      offer(OP_POP, TYPE_W'($urandom), $urandom, $urandom, $urandom);
   endtask

   // Stops offering until every reply has been taken
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic program_code(input logic [TYPE_W-1:0] code);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= code;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      mouse_code   = code;
   endtask

   // Mostly a few shared button states so that moves coalesce
   function automatic logic [ARG_W-1:0] button_state();
      if ($urandom_range(0, 4) == 0) return $urandom;
      return $urandom_range(0, 2);
   endfunction

   function automatic logic [TYPE_W-1:0] some_type();
      if ($urandom_range(0, 1) == 0) return mouse_code;
      return TYPE_W'($urandom_range(0, 15));
   endfunction

   // A run of pointer moves with occasional button changes and other events
   task automatic pointer_burst();
      logic [ARG_W-1:0] buttons;
      int               n;
      buttons = button_state();
      n       = $urandom_range(3, 14);
      repeat (n) begin
         if ($urandom_range(0, 4) == 0) buttons = button_state();
         if ($urandom_range(0, 6) == 0)
            offer(OP_PUSH, some_type(), $urandom, $urandom, button_state());
         else
            offer(OP_PUSH, mouse_code, $urandom, $urandom, buttons);
      end
      repeat ($urandom_range(0, 4)) pop_event();
   endtask

   // Pushes to about capacity or past it, then two moves that append and one that coalesces
   task automatic fill_ring();
      logic [ARG_W-1:0] buttons;
      repeat ($urandom_range(QUEUE_SLOTS - 4, QUEUE_SLOTS + 10))
         offer(OP_PUSH, some_type(), $urandom, $urandom, button_state());
      buttons = button_state();
      offer(OP_PUSH, mouse_code, $urandom, $urandom, ~buttons);
      offer(OP_PUSH, mouse_code, $urandom, $urandom, buttons);
      offer(OP_PUSH, mouse_code, $urandom, $urandom, buttons);
   endtask

   task automatic drain_ring();
      repeat ($urandom_range(1, QUEUE_SLOTS + 4)) pop_event();
   endtask

   task automatic mixed_noise();
      repeat ($urandom_range(5, 30)) begin
         if ($urandom_range(0, 1) == 0)
            offer(OP_PUSH, TYPE_W'($urandom), $urandom, $urandom, $urandom);
         else
            pop_event();
      end
   endtask

   initial begin : stimulus
      logic [TYPE_W-1:0] codes [PHASES];
      int                target;
      reset          <= 1'b1;
      csr_wr_en      <= 1'b0;
      csr_wr_data    <= '0;
      req_valid      <= 1'b0;
      req_opcode     <= OP_PUSH;
      req_event_type <= '0;
      req_arg_a      <= '0;
      req_arg_b      <= '0;
      req_arg_c      <= '0;
      codes = '{4'd0, 4'd15, 4'd5, MOUSE_CODE_RESET, 4'd10, 4'd3, 4'd12, 4'd1};
      codes[4] = TYPE_W'($urandom_range(0, 15));
      codes[6] = TYPE_W'($urandom_range(0, 15));
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part with the reset code: empty pops, coalescing rules, extremes
      pop_event();
      offer(OP_PUSH, 4'd0, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
      offer(OP_PUSH, mouse_code, 32'h0, 32'h0, 32'h0);
      offer(OP_PUSH, mouse_code, 32'h7fff_ffff, 32'h8000_0000, 32'h0);
      offer(OP_PUSH, mouse_code, 32'hffff_ffff, 32'h1, 32'h1);
      offer(OP_PUSH, 4'd15, 32'hffff_ffff, 32'hffff_ffff, 32'h1);
      offer(OP_PUSH, mouse_code, 32'h1234_5678, 32'h8765_4321, 32'h1);
      offer(OP_PUSH, mouse_code, 32'h8000_0000, 32'h7fff_ffff, 32'h1);
      repeat (7) pop_event();
      // a move into an empty ring appends
      offer(OP_PUSH, mouse_code, 32'h5a5a_5a5a, 32'ha5a5_a5a5, 32'h0);
      pop_event();
      // equal buttons on a non-pointer type never coalesce
      offer(OP_PUSH, 4'd0, 32'h1, 32'h2, 32'h0);
      offer(OP_PUSH, 4'd0, 32'h3, 32'h4, 32'h0);
      pop_event();
      pop_event();
      pop_event();

      // Random phases, one pointer code each, the last one without idling
      for (int p = 0; p < PHASES; p++) begin
         settle();
         program_code(codes[p]);
         if (p == 1) begin
            // hold replies back while the sender keeps offering
            hold_replies   = 1'b1;
            sender_idles   = 1'b0;
            receiver_idles = 1'b0;
            fill_ring();
         end
         target = requests_sent + PHASE_ITEMS;
         while (requests_sent < target) begin
            sender_idles   = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
            receiver_idles = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
               0, 1, 2: pointer_burst();
               3, 4:    fill_ring();
               5, 6:    drain_ring();
               default: mixed_noise();
            endcase
         end
      end

      settle();
      repeat (10) @(posedge clock);
      $display("covered %0d requests under %0d pointer-code settings, codes 0 and 15 included",
               requests_sent, PHASES + 1);
      $display("checked %0d replies: %0d moves coalesced, %0d oldest entries dropped",
               replies_checked, coalesced_count, dropped_count);
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
